@@ sv/mmfr_pkg.sv @@
// package for the minmod face reconstruction block
// widths, payload structs and the per-cell pipeline record; no dependencies
`default_nettype none
package mmfr_pkg;
  localparam int DataWidth = 32;
  localparam int WidthBits = 31;
  localparam int DiffBits  = 33;
  localparam int SumBits   = 32;
  localparam int MagBits   = 32;
  localparam int ProdBits  = 63;   // 31-bit width times 32-bit magnitude
  localparam int QuotBits  = 32;   // quotient never exceeds the chosen gradient magnitude

  typedef struct packed {
    logic signed [DataWidth-1:0] value_behind;
    logic signed [DataWidth-1:0] value_center;
    logic signed [DataWidth-1:0] value_ahead;
    logic [WidthBits-1:0]        width_behind;
    logic [WidthBits-1:0]        width_center;
    logic [WidthBits-1:0]        width_ahead;
    logic                        floor_at_zero;
  } mmfr_in_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] face_plus;
    logic signed [DataWidth-1:0] face_minus;
  } mmfr_out_t;

  // record handed along the divider cell row
  typedef struct packed {
    logic                        valid;
    logic                        enable;
    logic                        floor_on;
    logic                        neg;
    logic signed [DataWidth-1:0] center;
    logic [ProdBits-1:0]         rem;
    logic [SumBits-1:0]          divisor;
    logic [QuotBits-1:0]         quot;
  } mmfr_cell_t;
endpackage
`default_nettype wire

@@ sv/mmfr_if.sv @@
// valid/ready channel carrying one payload beat
// depends on mmfr_pkg for nothing; payload type is a type parameter
`default_nettype none
interface mmfr_if #(parameter type payload_t = logic) (input wire logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ sv/minmod_face_reconstruction.sv @@
// Minmod face reconstruction: one item per cycle in while the output is not stalled, one result
// per item out (three front stages for differences, cross products and slope numerator, a row
// of 32 division cells taking one quotient bit each, then the output register, ahead of which
// sign, saturation and floor are applied). The row of division cells makes up most of the
// pipeline; the whole row advances when the output register is free or being taken.
// depends on mmfr_pkg, mmfr_if and mmfr_div_cell
`default_nettype none
module minmod_face_reconstruction (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic cfg_wdata,
  mmfr_if.sink   in_ch,
  mmfr_if.source out_ch
);
  import mmfr_pkg::*;
  localparam int NCells = QuotBits;

  logic limiter_enable;
  logic advance;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) limiter_enable <= 1'b1;
    else if (cfg_we) limiter_enable <= cfg_wdata;
  end

  assign advance = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = advance;

  // stage a: differences, width sums
  logic a_valid, a_enable, a_floor;
  logic signed [DataWidth-1:0] a_center;
  logic signed [DiffBits-1:0] a_dr, a_dl;
  logic [SumBits-1:0] a_sr, a_sl;
  logic [WidthBits-1:0] a_wc;
  always_ff @(posedge clk) begin
    if (rst) a_valid <= 1'b0;
    else if (advance) a_valid <= in_ch.valid;
    if (advance) begin
      a_enable <= limiter_enable;
      a_floor  <= in_ch.data.floor_at_zero;
      a_center <= in_ch.data.value_center;
      a_dr <= DiffBits'(in_ch.data.value_ahead) - DiffBits'(in_ch.data.value_center);
      a_dl <= DiffBits'(in_ch.data.value_center) - DiffBits'(in_ch.data.value_behind);
      a_sr <= SumBits'(in_ch.data.width_center) + SumBits'(in_ch.data.width_ahead);
      a_sl <= SumBits'(in_ch.data.width_center) + SumBits'(in_ch.data.width_behind);
      a_wc <= in_ch.data.width_center;
    end
  end

  // stage b: magnitudes and cross products for the minmod compare
  logic [MagBits-1:0] mr, ml;
  assign mr = a_dr[DiffBits-1] ? MagBits'(-a_dr) : MagBits'(a_dr);
  assign ml = a_dl[DiffBits-1] ? MagBits'(-a_dl) : MagBits'(a_dl);
  logic b_valid, b_enable, b_floor, b_zero, b_neg;
  logic signed [DataWidth-1:0] b_center;
  logic [MagBits-1:0] b_mr, b_ml;
  logic [SumBits-1:0] b_sr, b_sl;
  logic [WidthBits-1:0] b_wc;
  logic [MagBits+SumBits-1:0] b_xr, b_xl;
  always_ff @(posedge clk) begin
    if (rst) b_valid <= 1'b0;
    else if (advance) b_valid <= a_valid;
    if (advance) begin
      b_enable <= a_enable;
      b_floor  <= a_floor;
      b_center <= a_center;
      b_zero   <= (a_wc == '0) || (a_dr == '0) || (a_dl == '0) ||
                  (a_dr[DiffBits-1] != a_dl[DiffBits-1]);
      b_neg <= a_dr[DiffBits-1];
      b_mr <= mr; b_ml <= ml; b_sr <= a_sr; b_sl <= a_sl; b_wc <= a_wc;
      b_xr <= (MagBits+SumBits)'(mr) * (MagBits+SumBits)'(a_sl);
      b_xl <= (MagBits+SumBits)'(ml) * (MagBits+SumBits)'(a_sr);
    end
  end

  // stage c: pick the smaller gradient, form numerator width times magnitude
  logic pick_r;
  assign pick_r = b_xr < b_xl;
  mmfr_cell_t row [NCells+1];
  always_ff @(posedge clk) begin
    if (rst) row[0].valid <= 1'b0;
    else if (advance) row[0].valid <= b_valid;
    if (advance) begin
      row[0].enable   <= b_enable;
      row[0].floor_on <= b_floor;
      row[0].neg      <= b_neg;
      row[0].center   <= b_center;
      row[0].quot     <= '0;
      row[0].divisor  <= pick_r ? b_sr : b_sl;
      row[0].rem      <= b_zero ? '0 : ProdBits'(b_wc) * ProdBits'(pick_r ? b_mr : b_ml);
    end
  end

  // division cells, most significant quotient bit first
  for (genvar i = 0; i < NCells; i++) begin : g_cell
    mmfr_div_cell u_cell (
      .clk(clk), .rst(rst), .advance(advance),
      .bit_pos(6'(NCells - 1 - i)),
      .cell_in(row[i]), .cell_out(row[i+1])
    );
  end

  // output: sign, saturate, floor; pass the center value through when the limiter is off
  mmfr_cell_t last;
  logic signed [DataWidth+1:0] slope, p_full, m_full;
  logic signed [DataWidth-1:0] p_sat, m_sat;
  localparam logic signed [DataWidth+1:0] Hi = (DataWidth+2)'({(DataWidth-1){1'b1}});
  localparam logic signed [DataWidth+1:0] Lo = -Hi - 1;
  assign last = row[NCells];
  always_comb begin
    slope  = last.neg ? -(DataWidth+2)'(last.quot) : (DataWidth+2)'(last.quot);
    p_full = (DataWidth+2)'(last.center) + slope;
    m_full = (DataWidth+2)'(last.center) - slope;
    p_sat = p_full > Hi ? DataWidth'(Hi) : p_full < Lo ? DataWidth'(Lo) : DataWidth'(p_full);
    m_sat = m_full > Hi ? DataWidth'(Hi) : m_full < Lo ? DataWidth'(Lo) : DataWidth'(m_full);
    if (last.floor_on && p_sat < 0) p_sat = '0;
    if (last.floor_on && m_sat < 0) m_sat = '0;
    if (!last.enable) begin
      p_sat = last.center;
      m_sat = last.center;
    end
  end
  always_ff @(posedge clk) begin
    if (rst) out_ch.valid <= 1'b0;
    else if (advance) out_ch.valid <= last.valid;
    if (advance) begin
      out_ch.data.face_plus  <= p_sat;
      out_ch.data.face_minus <= m_sat;
    end
  end
endmodule
`default_nettype wire

@@ sv/mmfr_div_cell.sv @@
// one restoring division step of the row; holds a single record
// depends on mmfr_pkg
`default_nettype none
module mmfr_div_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire logic [5:0]      bit_pos,
  input  wire mmfr_pkg::mmfr_cell_t cell_in,
  output mmfr_pkg::mmfr_cell_t cell_out
);
  import mmfr_pkg::*;
  mmfr_cell_t step;
  logic [ProdBits+SumBits-1:0] shifted;
  always_comb begin
    step = cell_in;
    shifted = {{SumBits{1'b0}}, cell_in.divisor} << bit_pos;
    if (cell_in.rem >= shifted[ProdBits-1:0] && shifted[ProdBits+SumBits-1:ProdBits] == '0) begin
      step.rem = cell_in.rem - shifted[ProdBits-1:0];
      step.quot[bit_pos[4:0]] = 1'b1;
    end
  end
  // register the step
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_out.valid <= 1'b0;
    end else if (advance) begin
      cell_out.valid <= cell_in.valid;
    end
    if (advance) begin
      cell_out.enable   <= step.enable;
      cell_out.floor_on <= step.floor_on;
      cell_out.neg      <= step.neg;
      cell_out.center   <= step.center;
      cell_out.rem      <= step.rem;
      cell_out.divisor  <= step.divisor;
      cell_out.quot     <= step.quot;
    end
  end
endmodule
`default_nettype wire

@@ sv/mmfr_checker.sv @@
// port-level checks for the face reconstruction block, bound to the top level
// depends on nothing but the top level minmod_face_reconstruction, to which it is bound
`default_nettype none
module mmfr_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic [63:0] out_data
);
  // a waiting result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data)) else $error("out beat changed");
  // input is ready whenever the output side is free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready) else $error("stall without back-pressure");
  // stalled output blocks input
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready) else $error("input taken during stall");
  // no result right after reset
  a_rst: assert property (@(posedge clk) $past(rst) |-> !out_valid) else $error("beat after reset");
endmodule
bind minmod_face_reconstruction mmfr_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data));
`default_nettype wire
